### hw/rtl/bmp_pixel_stream_decoder_assert.svh
// Assertion macros for the BMP pixel stream decoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BMP_PIXEL_STREAM_DECODER_ASSERT_SVH
`define BMP_PIXEL_STREAM_DECODER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BMPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BMPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bmpd_pkg.sv
// Shared types and constants for the BMP pixel stream decoder.
// No dependencies.
`default_nettype none

package bmpd_pkg;

  localparam int PIX_W   = 12;
  localparam int COLOR_W = 24;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [15:0] DEPTH_32      = 16'd32;

  // Byte positions of the packed header fields
  localparam int SIG_POS    = 0;
  localparam int OFFSET_POS = 10;
  localparam int WIDTH_POS  = 18;
  localparam int HEIGHT_POS = 22;
  localparam int DEPTH_POS  = 28;
  localparam int CHECK_POS  = 29;
  localparam int HEADER_END = 54;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_OFFSET = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    status_t            status;
    logic               last_pixel;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/bmpd_if.sv
// Valid/ready channel interfaces for the byte input and the pixel result.
// Depends on bmpd_pkg.
`default_nettype none

interface bmpd_in_if import bmpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source(output valid, output data_byte, output start_of_file, input ready);
  modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bmpd_out_if import bmpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic [2:0]         status;
  logic               last_pixel;

  modport source(output valid, output pixel_x, output pixel_y, output pixel_color,
                 output status, output last_pixel, input ready);
  modport sink(input valid, input pixel_x, input pixel_y, input pixel_color,
               input status, input last_pixel, output ready);
endinterface

`default_nettype wire

### hw/rtl/bmpd_in_stage.sv
// Input register of the decoder: holds one byte request until the core takes it.
// Depends on bmpd_pkg and bmpd_if.
`default_nettype none

module bmpd_in_stage import bmpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bmpd_in_if.sink   in_if,
  input  logic      take_i,
  output logic      fire_o,
  output in_item_t  item_o
);

  logic     valid_r;
  in_item_t item_r;
  logic     accept;

  assign in_if.ready = !valid_r || take_i;
  assign accept      = in_if.valid && in_if.ready;
  assign fire_o      = valid_r && take_i;
  assign item_o      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte     <= in_if.data_byte;
      item_r.start_of_file <= in_if.start_of_file;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bmpd_core.sv
// Header parser and pixel unpacker: one byte per cycle while fire_i is high, parse state in registers.
// Depends on bmpd_pkg and bmp_pixel_stream_decoder_assert.svh.
`default_nettype none
`include "bmp_pixel_stream_decoder_assert.svh"

module bmpd_core import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire_i,
  input  in_item_t item_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  phase_t          phase_r, phase_nxt, cur_phase;
  logic [31:0]     pos_r, pos_nxt, cur_pos;
  logic [15:0]     sig_r, sig_nxt, cur_sig;
  logic [31:0]     offset_r, offset_nxt, cur_offset;
  logic [31:0]     width_r, width_nxt, cur_width;
  logic [31:0]     height_r, height_nxt, cur_height;
  logic [15:0]     depth_r, depth_nxt, cur_depth;
  logic [CW-1:0]   column_r, column_nxt, cur_column;
  logic [RW-1:0]   row_r, row_nxt, cur_row;
  logic [RW-1:0]   habs_r, habs_nxt, cur_habs;
  logic [1:0]      pb_r, pb_nxt, cur_pb;
  logic [7:0]      blue_r, blue_nxt, cur_blue;
  logic [7:0]      green_r, green_nxt, cur_green;
  logic [1:0]      pad_r, pad_nxt, cur_pad;

  logic            sof;
  logic [7:0]      b;
  logic [1:0]      lane;
  logic            at_check;
  logic [15:0]     depth_full;
  logic [31:0]     habs32;
  status_t         chk;
  logic            check_fail;
  logic            skip_done;
  logic            pix_step;
  logic            bpp4;
  logic            emit;
  logic            last;
  logic            adv_pixel;
  logic [CW-1:0]   col_inc;
  logic [RW-1:0]   row_inc;

  // A start mark clears all state before the byte is taken
  assign sof        = item_i.start_of_file;
  assign b          = item_i.data_byte;
  assign cur_phase  = sof ? PH_HEADER : phase_r;
  assign cur_pos    = sof ? '0 : pos_r;
  assign cur_sig    = sof ? '0 : sig_r;
  assign cur_offset = sof ? '0 : offset_r;
  assign cur_width  = sof ? '0 : width_r;
  assign cur_height = sof ? '0 : height_r;
  assign cur_depth  = sof ? '0 : depth_r;
  assign cur_column = sof ? '0 : column_r;
  assign cur_row    = sof ? '0 : row_r;
  assign cur_habs   = sof ? '0 : habs_r;
  assign cur_pb     = sof ? '0 : pb_r;
  assign cur_blue   = sof ? '0 : blue_r;
  assign cur_green  = sof ? '0 : green_r;
  assign cur_pad    = sof ? '0 : pad_r;

  // 32-bit fields start at a position with low bits 2'b10
  assign lane       = 2'(cur_pos[1:0] - 2'd2);
  assign at_check   = (cur_phase == PH_HEADER) && (cur_pos == 32'(CHECK_POS));
  assign depth_full = {b, cur_depth[7:0]};
  assign habs32     = cur_height[31] ? (~cur_height + 32'd1) : cur_height;

  always_comb begin
    chk = ST_PIXEL;
    if (cur_sig != BMP_SIGNATURE) begin
      chk = ST_BAD_SIG;
    end else if (depth_full != DEPTH_24 && depth_full != DEPTH_32) begin
      chk = ST_BAD_DEPTH;
    end else if (cur_width == '0 || cur_width > 32'(MAX_WIDTH) ||
                 habs32 == '0 || habs32 > 32'(MAX_HEIGHT)) begin
      chk = ST_BAD_SIZE;
    end else if (cur_offset < 32'(HEADER_END)) begin
      chk = ST_BAD_OFFSET;
    end
  end

  assign check_fail = at_check && (chk != ST_PIXEL);
  assign skip_done  = (cur_phase == PH_SKIP) && (32'(cur_pos + 32'd1) >= cur_offset);

  assign pix_step  = (cur_phase == PH_PIXELS) && (cur_pad == 2'd0);
  assign bpp4      = (cur_depth == DEPTH_32);
  assign col_inc   = CW'(cur_column + CW'(1));
  assign row_inc   = RW'(cur_row + RW'(1));
  assign emit      = pix_step && (cur_pb == 2'd2);
  assign last      = emit && (col_inc == cur_width[CW-1:0]) && (row_inc == cur_habs);
  assign adv_pixel = pix_step && ((cur_pb == 2'd3) || (cur_pb == 2'd2 && !bpp4));

  // Next phase
  always_comb begin
    phase_nxt = cur_phase;
    case (cur_phase)
      PH_HEADER: begin
        if (at_check) begin
          phase_nxt = check_fail ? PH_DONE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_done) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (last) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // Field capture and pixel counters
  always_comb begin
    pos_nxt    = (cur_pos == '1) ? cur_pos : 32'(cur_pos + 32'd1);
    sig_nxt    = cur_sig;
    offset_nxt = cur_offset;
    width_nxt  = cur_width;
    height_nxt = cur_height;
    depth_nxt  = cur_depth;
    column_nxt = cur_column;
    row_nxt    = cur_row;
    habs_nxt   = cur_habs;
    pb_nxt     = cur_pb;
    blue_nxt   = cur_blue;
    green_nxt  = cur_green;
    pad_nxt    = cur_pad;

    if (cur_phase == PH_HEADER) begin
      if (cur_pos inside {[SIG_POS:SIG_POS+1]}) begin
        sig_nxt[cur_pos[0]*8 +: 8] = b;
      end else if (cur_pos inside {[OFFSET_POS:OFFSET_POS+3]}) begin
        offset_nxt[lane*8 +: 8] = b;
      end else if (cur_pos inside {[WIDTH_POS:WIDTH_POS+3]}) begin
        width_nxt[lane*8 +: 8] = b;
      end else if (cur_pos inside {[HEIGHT_POS:HEIGHT_POS+3]}) begin
        height_nxt[lane*8 +: 8] = b;
      end else if (cur_pos inside {[DEPTH_POS:DEPTH_POS+1]}) begin
        depth_nxt[cur_pos[0]*8 +: 8] = b;
      end
      if (at_check) begin
        habs_nxt = RW'(habs32);
      end
    end

    if (cur_phase == PH_PIXELS) begin
      if (cur_pad != 2'd0) begin
        pad_nxt = 2'(cur_pad - 2'd1);
      end else begin
        case (cur_pb)
          2'd0: begin
            blue_nxt = b;
            pb_nxt   = 2'd1;
          end
          2'd1: begin
            green_nxt = b;
            pb_nxt    = 2'd2;
          end
          default: begin
            if (!last) begin
              if (adv_pixel) begin
                pb_nxt     = 2'd0;
                column_nxt = col_inc;
                if (col_inc >= cur_width[CW-1:0]) begin
                  column_nxt = '0;
                  row_nxt    = row_inc;
                  // 24-bit rows pad by width mod 4 bytes, 32-bit rows never pad
                  pad_nxt    = bpp4 ? 2'd0 : cur_width[1:0];
                end
              end else begin
                pb_nxt = 2'(cur_pb + 2'd1);
              end
            end
          end
        endcase
      end
    end
  end

  // Result
  always_comb begin
    res_o.pixel_x     = PIX_W'(cur_column);
    res_o.pixel_y     = cur_height[31] ? PIX_W'(cur_row)
                                       : PIX_W'(RW'(cur_habs - RW'(1) - cur_row));
    res_o.pixel_color = {b, cur_green, cur_blue};
    res_o.status      = ST_PIXEL;
    res_o.last_pixel  = last;
    if (check_fail) begin
      res_o.pixel_x     = '0;
      res_o.pixel_y     = '0;
      res_o.pixel_color = '0;
      res_o.status      = chk;
      res_o.last_pixel  = 1'b0;
    end
  end

  assign res_valid_o = fire_i && (check_fail || emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      sig_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      column_r <= '0;
      row_r    <= '0;
      habs_r   <= '0;
      pb_r     <= '0;
      blue_r   <= '0;
      green_r  <= '0;
      pad_r    <= '0;
    end else if (fire_i) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      sig_r    <= sig_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      habs_r   <= habs_nxt;
      pb_r     <= pb_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      pad_r    <= pad_nxt;
    end
  end

  `BMPD_ASSERT_NEXT(a_last_ends_image, res_valid_o && res_o.last_pixel, phase_r == PH_DONE, "last pixel did not end the image")
  `BMPD_ASSERT_NEXT(a_error_ends_file, res_valid_o && res_o.status != ST_PIXEL, phase_r == PH_DONE, "error did not stop parsing")
  `BMPD_ASSERT_NOW(a_error_payload_zero, res_valid_o && res_o.status != ST_PIXEL, res_o.pixel_x == '0 && res_o.pixel_y == '0 && res_o.pixel_color == '0 && !res_o.last_pixel, "error request carries nonzero payload")
  `BMPD_ASSERT_NOW(a_position_in_image, phase_r == PH_PIXELS, column_r < width_r[CW-1:0] && row_r < habs_r, "pixel position outside image")

endmodule

`default_nettype wire

### hw/rtl/bmpd_out_stage.sv
// Result register of the decoder: holds one result request until the sink takes it.
// Depends on bmpd_pkg and bmpd_if.
`default_nettype none

module bmpd_out_stage import bmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid_i,
  input  result_t    res_i,
  output logic       take_o,
  bmpd_out_if.source out_if
);

  logic    valid_r;
  result_t res_r;

  // Advance when the slot is empty or being drained this cycle
  assign take_o = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_o) begin
      valid_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (take_o && res_valid_i) begin
      res_r <= res_i;
    end
  end

  assign out_if.valid       = valid_r;
  assign out_if.pixel_x     = res_r.pixel_x;
  assign out_if.pixel_y     = res_r.pixel_y;
  assign out_if.pixel_color = res_r.pixel_color;
  assign out_if.status      = res_r.status;
  assign out_if.last_pixel  = res_r.last_pixel;

endmodule

`default_nettype wire

### hw/rtl/bmp_pixel_stream_decoder.sv
// BMP pixel stream decoder, top level: input register, parser core, result register.
// A byte is held in the input register, decoded by the core, and its result held in the result register.
// Throughput: one byte per cycle; while a result waits, the core holds and the input
// register takes at most one more byte.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to byte 0.
// Depends on bmpd_pkg, bmpd_if, bmpd_in_stage, bmpd_core and bmpd_out_stage.
`default_nettype none

module bmp_pixel_stream_decoder import bmpd_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bmpd_in_if.sink    in_if,
  bmpd_out_if.source out_if
);

  logic     take;
  logic     fire;
  in_item_t item;
  logic     res_valid;
  result_t  res;

  bmpd_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .take_i (take),
    .fire_o (fire),
    .item_o (item)
  );

  bmpd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmpd_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (take),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
